FILE: rtl/cms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cms_pkg
// Types and constants shared by the charlieplexed matrix scanner files.
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam int ROWS    = 19;
    localparam int COLS    = 18;
    localparam int PLANES  = 2;

    localparam int ROW_W   = 5;
    localparam int BITS_W  = 18;
    localparam int PINS_W  = 19;
    localparam int DWELL_W = 16;
    localparam int CFG_W   = 16;

    localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PLANE_W = (PLANES > 1) ? $clog2(PLANES) : 1;

    localparam logic [DWELL_W-1:0] PLANE0_RESET = 16'd20;
    localparam logic [DWELL_W-1:0] PLANE1_RESET = 16'd40;

    typedef logic [ROW_AW-1:0]  row_t;
    typedef logic [PLANE_W-1:0] plane_t;
    typedef logic [COLS-1:0]    cols_t;
    typedef logic [ROWS-1:0]    pins_t;
    typedef logic [DWELL_W-1:0] dwell_t;
    typedef logic [DWELL_W:0]   dwell_ext_t;
    typedef logic [ROW_W-1:0]   row_field_t;
    typedef logic [BITS_W-1:0]  bits_field_t;
    typedef logic [PINS_W-1:0]  pins_field_t;
    typedef logic [CFG_W-1:0]   cfg_data_t;

    typedef enum logic
    {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic
    {
        CFG_PLANE0 = 1'b0,
        CFG_PLANE1 = 1'b1
    } cfg_idx_t;

endpackage
`default_nettype wire

FILE: rtl/cms_item_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cms_item_if
// Input channel of the scanner: timer ticks and row writes.
// ----------------------------------------------------------------------------
interface cms_item_if;

    logic                 valid;
    logic                 ready;
    cms_pkg::op_t         opcode;
    cms_pkg::row_field_t  row_index;
    cms_pkg::bits_field_t row_bits;

    modport source (output valid, output opcode, output row_index, output row_bits,
                    input ready);
    modport sink   (input valid, input opcode, input row_index, input row_bits,
                    output ready);

endinterface
`default_nettype wire

FILE: rtl/cms_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cms_result_if
// Output channel of the scanner: pin drive for the row on display.
// ----------------------------------------------------------------------------
interface cms_result_if;

    logic                 valid;
    logic                 ready;
    cms_pkg::pins_field_t pin_drive;
    cms_pkg::pins_field_t pin_level;
    cms_pkg::row_field_t  shown_row;
    logic                 shown_plane;

    modport source (output valid, output pin_drive, output pin_level,
                    output shown_row, output shown_plane, input ready);
    modport sink   (input valid, input pin_drive, input pin_level,
                    input shown_row, input shown_plane, output ready);

endinterface
`default_nettype wire

FILE: rtl/cms_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cms_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                               clk,
    input  wire logic                               we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                   wdata,
    input  wire logic                               re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                   rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/charlieplex_matrix_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// charlieplex_matrix_scanner
// Scans a charlieplexed LED matrix held in a row memory and gives the pin
// drive of the row on display for every input beat.
//
// The item channel carries ticks and row writes; each accepted beat yields
// exactly one beat on the result channel, in order. A tick advances the dwell
// counter and may step the scan to the next row and bit plane; a write stores
// one row word (a row index past the last row is dropped) and leaves the scan
// where it is. Registers plane0_reg and plane1_reg are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce.
// Each beat passes the registered row memory read, then the output register.
// Throughput is one beat per cycle while the receiver does not stall, set by
// the single read and write port of the row memory. A write to the row being
// read in the same cycle is forwarded around the memory.
// Reset clears the counters, marks every row dark and loads the dwell
// registers with 20 and 40 ticks. When the receiver stalls, the output
// register holds its beat, one more beat is taken into the read stage, and
// then ready drops until the output drains.
// ----------------------------------------------------------------------------
module charlieplex_matrix_scanner (
    input  wire logic              clk,
    input  wire logic              rst_n,
    cms_item_if.sink               item,
    cms_result_if.source           result,
    input  wire logic              cfg_we,
    input  wire cms_pkg::cfg_idx_t cfg_index,
    input  wire cms_pkg::cfg_data_t cfg_data
);

    function automatic cms_pkg::pins_t drive_of(cms_pkg::row_t row, cms_pkg::cols_t bits);
        cms_pkg::pins_t d;
        int anode;
        int pin;
        anode = cms_pkg::ROWS - 1 - int'(row);
        d = cms_pkg::pins_t'(1) << anode;
        for (int c = 0; c < cms_pkg::COLS; c++)
        begin
            pin = (c < anode) ? c : c + 1;
            if (bits[c] && (pin < cms_pkg::ROWS))
            begin
                d[pin] = 1'b1;
            end
        end
        return d;
    endfunction

    cms_pkg::dwell_t plane0_reg;
    cms_pkg::dwell_t plane1_reg;
    cms_pkg::dwell_t dwell_reg;
    cms_pkg::dwell_t dwell_next;
    cms_pkg::row_t   row_reg;
    cms_pkg::row_t   row_next;
    cms_pkg::plane_t plane_reg;
    cms_pkg::plane_t plane_next;
    cms_pkg::pins_t  written_reg;

    logic            s1_valid_reg;
    cms_pkg::row_t   s1_row_reg;
    cms_pkg::plane_t s1_plane_reg;
    logic            s1_fwd_reg;
    logic            s1_written_reg;
    cms_pkg::cols_t  s1_fwd_data_reg;

    logic            out_valid_reg;
    cms_pkg::pins_t  out_drive_reg;
    cms_pkg::pins_t  out_level_reg;
    cms_pkg::row_t   out_row_reg;
    cms_pkg::plane_t out_plane_reg;

    logic              accept;
    logic              s1_move;
    logic              is_write;
    logic              wr_en;
    cms_pkg::row_t     wr_row;
    cms_pkg::cols_t    wr_data;
    cms_pkg::dwell_t   limit;
    cms_pkg::dwell_ext_t dwell_inc;
    logic              step;
    cms_pkg::cols_t    ram_q;
    cms_pkg::cols_t    s1_bits;

    assign s1_move     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready  = !s1_valid_reg || s1_move;
    assign accept      = item.valid && item.ready;
    assign is_write    = (item.opcode == cms_pkg::OP_WRITE);
    assign wr_row      = cms_pkg::row_t'(item.row_index);
    assign wr_data     = cms_pkg::cols_t'(item.row_bits);
    assign wr_en       = accept && is_write && (int'(item.row_index) < cms_pkg::ROWS);

    always_comb
    begin
        limit = (plane_reg == cms_pkg::plane_t'(0)) ? plane0_reg : plane1_reg;
        if (limit == cms_pkg::dwell_t'(0))
        begin
            limit = cms_pkg::dwell_t'(1);
        end
        dwell_inc  = cms_pkg::dwell_ext_t'(dwell_reg) + cms_pkg::dwell_ext_t'(1);
        step       = (dwell_inc >= cms_pkg::dwell_ext_t'(limit));
        dwell_next = dwell_reg;
        row_next   = row_reg;
        plane_next = plane_reg;
        if (!is_write)
        begin
            if (step)
            begin
                dwell_next = cms_pkg::dwell_t'(0);
                if (row_reg == cms_pkg::row_t'(cms_pkg::ROWS - 1))
                begin
                    row_next = cms_pkg::row_t'(0);
                    if (plane_reg == cms_pkg::plane_t'(cms_pkg::PLANES - 1))
                    begin
                        plane_next = cms_pkg::plane_t'(0);
                    end
                    else
                    begin
                        plane_next = plane_reg + cms_pkg::plane_t'(1);
                    end
                end
                else
                begin
                    row_next = row_reg + cms_pkg::row_t'(1);
                end
            end
            else
            begin
                dwell_next = dwell_inc[cms_pkg::DWELL_W-1:0];
            end
        end
    end

    cms_ram #(
        .WIDTH (cms_pkg::COLS),
        .DEPTH (cms_pkg::ROWS)
    ) u_frame (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_row),
        .wdata (wr_data),
        .re    (accept),
        .raddr (row_next),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane0_reg    <= cms_pkg::PLANE0_RESET;
            plane1_reg    <= cms_pkg::PLANE1_RESET;
            dwell_reg     <= '0;
            row_reg       <= '0;
            plane_reg     <= '0;
            written_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    cms_pkg::CFG_PLANE0: plane0_reg <= cfg_data;
                    cms_pkg::CFG_PLANE1: plane1_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                dwell_reg <= dwell_next;
                row_reg   <= row_next;
                plane_reg <= plane_next;
            end
            if (wr_en)
            begin
                written_reg[wr_row] <= 1'b1;
            end
            if (item.ready)
            begin
                s1_valid_reg <= accept;
            end
            if (!out_valid_reg || result.ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg      <= row_next;
            s1_plane_reg    <= plane_next;
            s1_fwd_reg      <= wr_en && (wr_row == row_next);
            s1_fwd_data_reg <= wr_data;
            s1_written_reg  <= written_reg[row_next];
        end
        if (s1_move)
        begin
            out_drive_reg <= drive_of(s1_row_reg, s1_bits);
            out_level_reg <= cms_pkg::pins_t'(1) << (cms_pkg::ROWS - 1 - int'(s1_row_reg));
            out_row_reg   <= s1_row_reg;
            out_plane_reg <= s1_plane_reg;
        end
    end

    assign s1_bits = s1_fwd_reg     ? s1_fwd_data_reg :
                     s1_written_reg ? ram_q : cms_pkg::cols_t'(0);

    assign result.valid       = out_valid_reg;
    assign result.pin_drive   = cms_pkg::pins_field_t'(out_drive_reg);
    assign result.pin_level   = cms_pkg::pins_field_t'(out_level_reg);
    assign result.shown_row   = cms_pkg::row_field_t'(out_row_reg);
    assign result.shown_plane = out_plane_reg[0];

endmodule
`default_nettype wire

FILE: rtl/cms_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cms_checker
// Port-level checks of the scanner result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cms_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire cms_pkg::pins_field_t pin_drive,
    input wire cms_pkg::pins_field_t pin_level,
    input wire cms_pkg::row_field_t  shown_row
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pin_drive) && $stable(shown_row))
        else $error("result beat changed while stalled");

    a_one_anode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(pin_level))
        else $error("result does not have exactly one anode pin");

    a_anode_driven: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((pin_drive & pin_level) == pin_level))
        else $error("anode pin is not driven");

    a_anode_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(shown_row) < cms_pkg::ROWS)
            && pin_level[cms_pkg::ROWS - 1 - int'(shown_row)])
        else $error("anode pin does not match the shown row");

endmodule

bind charlieplex_matrix_scanner cms_checker u_cms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .pin_drive (result.pin_drive),
    .pin_level (result.pin_level),
    .shown_row (result.shown_row)
);
`default_nettype wire
